// ===== src/lru_cache_directory_unit_defines.svh =====
// ---------------------------------------------------------------------------
// lru cache directory unit assertion macros
// concurrent checks clocked on clk, quiet while arst_n is low
// ---------------------------------------------------------------------------
`ifndef LRU_CACHE_DIRECTORY_UNIT_DEFINES_SVH
`define LRU_CACHE_DIRECTORY_UNIT_DEFINES_SVH

// same-cycle implication
`define LRUD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LRUD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/lrud_pkg.sv =====
// ---------------------------------------------------------------------------
// lru cache directory package
// shared constants, command codes and controller/datapath interface types
// ---------------------------------------------------------------------------
package lrud_pkg;

	localparam int DEF_ENTRIES  = 16;
	localparam int DEF_KEY_BITS = 64;

	localparam int KEY_W   = 64;
	localparam int INDEX_W = 4;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	typedef struct packed {
		logic capture;
		logic compare;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic slot_free;
	} dp_status_t;

endpackage

// ===== src/lrud_ctrl.sv =====
// ---------------------------------------------------------------------------
// lru cache directory controller
// sequences capture, compare and update for one request at a time
// ---------------------------------------------------------------------------
`include "lru_cache_directory_unit_defines.svh"

module lrud_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lrud_pkg::dp_status_t status,
	output lrud_pkg::ctl_cmd_t   cmd
);
	import lrud_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	state_t state_q;

	assign in_ready    = (state_q == ST_IDLE);
	assign cmd.capture = in_valid && (state_q == ST_IDLE);
	assign cmd.compare = (state_q == ST_CMP);
	assign cmd.commit  = (state_q == ST_UPD) && status.slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (status.slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`LRUD_ASSERT_NEXT(a_capture_then_compare, cmd.capture, state_q == ST_CMP, "capture not followed by compare")
	`LRUD_ASSERT_NEXT(a_update_holds, (state_q == ST_UPD) && !status.slot_free, state_q == ST_UPD, "update left while result slot busy")
	`LRUD_ASSERT_IMPL(a_single_command, 1'b1, $onehot0({cmd.capture, cmd.compare, cmd.commit}), "overlapping datapath commands")

endmodule

// ===== src/lrud_datapath.sv =====
// ---------------------------------------------------------------------------
// lru cache directory datapath
// entry keys, valid bits, recency ranks, match/victim search and result slot
// ---------------------------------------------------------------------------
`include "lru_cache_directory_unit_defines.svh"

module lrud_datapath #(
	parameter int ENTRIES  = lrud_pkg::DEF_ENTRIES,
	parameter int KEY_BITS = lrud_pkg::DEF_KEY_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lrud_pkg::ctl_cmd_t          cmd,
	output lrud_pkg::dp_status_t        status,
	input  logic                        command,
	input  logic [lrud_pkg::KEY_W-1:0]  key,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        hit,
	output logic [lrud_pkg::INDEX_W-1:0] entry_index,
	output logic                        evicted
);
	import lrud_pkg::*;

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int RANK_W = $clog2(ENTRIES);
	localparam logic [RANK_W-1:0] OLDEST = RANK_W'(ENTRIES - 1);

	logic                cmd_q;
	logic [KEY_BITS-1:0] key_q;

	logic [ENTRIES-1:0]  valid_q;
	logic [KEY_BITS-1:0] key_mem [ENTRIES];
	logic [RANK_W-1:0]   rank_q  [ENTRIES];

	logic [IDX_W-1:0]    idx_s1;
	logic [RANK_W-1:0]   old_rank_s1;
	logic                touch_s1;
	logic                evict_s1;

	logic                out_valid_q;
	logic                hit_q;
	logic [INDEX_W-1:0]  index_q;
	logic                evicted_q;

	logic [IDX_W-1:0]    m_idx;
	logic [RANK_W-1:0]   m_rank;
	logic                m_found;
	logic [IDX_W-1:0]    f_idx;
	logic                f_found;
	logic [IDX_W-1:0]    o_idx;
	logic [IDX_W+INDEX_W-1:0] idx_ext;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= command;
			key_q <= key[KEY_BITS-1:0];
		end
	end

	// lowest matching entry, lowest free entry, highest oldest entry
	always_comb begin
		m_idx   = '0;
		m_rank  = '0;
		m_found = 1'b0;
		f_idx   = '0;
		f_found = 1'b0;
		o_idx   = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && (key_mem[i] == key_q)) begin
				m_idx   = IDX_W'(i);
				m_rank  = rank_q[i];
				m_found = 1'b1;
			end
			if (!valid_q[i]) begin
				f_idx   = IDX_W'(i);
				f_found = 1'b1;
			end
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (rank_q[i] == OLDEST) begin
				o_idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_s1 <= 1'b0;
			evict_s1 <= 1'b0;
		end else if (cmd.compare) begin
			if (cmd_q == CMD_LOOKUP) begin
				touch_s1 <= m_found;
				evict_s1 <= 1'b0;
			end else begin
				touch_s1 <= 1'b1;
				evict_s1 <= !f_found;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			if (cmd_q == CMD_LOOKUP) begin
				idx_s1      <= m_idx;
				old_rank_s1 <= m_rank;
			end else begin
				idx_s1      <= f_found ? f_idx : o_idx;
				old_rank_s1 <= OLDEST;
			end
		end
	end

	// entry state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.commit && touch_s1) begin
			if (cmd_q == CMD_INSERT) begin
				valid_q[idx_s1] <= 1'b1;
			end
			for (int i = 0; i < ENTRIES; i++) begin
				if (IDX_W'(i) == idx_s1) begin
					rank_q[i] <= '0;
				end else if (rank_q[i] < old_rank_s1) begin
					rank_q[i] <= RANK_W'(rank_q[i] + 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && (cmd_q == CMD_INSERT)) begin
			key_mem[idx_s1] <= key_q;
		end
	end

	// result slot
	assign idx_ext = {{INDEX_W{1'b0}}, idx_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q     <= (cmd_q == CMD_LOOKUP) && touch_s1;
			index_q   <= idx_ext[INDEX_W-1:0];
			evicted_q <= evict_s1;
		end
	end

	assign status.slot_free = !out_valid_q || out_ready;
	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign entry_index = index_q;
	assign evicted     = evicted_q;

	`LRUD_ASSERT_IMPL(a_evict_only_when_full, cmd.commit && evict_s1, &valid_q, "eviction with a free entry")
	`LRUD_ASSERT_NEXT(a_insert_sets_valid, cmd.commit && (cmd_q == CMD_INSERT), valid_q[$past(idx_s1)], "inserted entry not valid")
	`LRUD_ASSERT_NEXT(a_touch_is_newest, cmd.commit && touch_s1, rank_q[$past(idx_s1)] == '0, "touched entry not most recent")
	`LRUD_ASSERT_IMPL(a_no_result_overrun, cmd.commit, !out_valid_q || out_ready, "result overwritten before delivery")

endmodule

// ===== src/lru_cache_directory_unit.sv =====
// ---------------------------------------------------------------------------
// lru cache directory unit
// directory of a fully associative cache with least-recently-used replacement
// ---------------------------------------------------------------------------
// Each request (lookup or insert of a key) passes three steps: capture,
// parallel key compare and free/victim search over all entries, then the
// update of valid bits, keys and recency ranks and the result register
// load. The controller takes one request at a time, so a new one is
// accepted only once the last is updated; the result register lets the
// next request enter while the previous result still waits for
// out_ready. Valid bits and ranks clear at reset: no clearing pass needed.
// ---------------------------------------------------------------------------
module lru_cache_directory_unit #(
	parameter int ENTRIES  = lrud_pkg::DEF_ENTRIES,
	parameter int KEY_BITS = lrud_pkg::DEF_KEY_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         command,
	input  logic [lrud_pkg::KEY_W-1:0]   key,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic [lrud_pkg::INDEX_W-1:0] entry_index,
	output logic                         evicted
);
	import lrud_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t status;

	lrud_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	lrud_datapath #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.command     (command),
		.key         (key),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.entry_index (entry_index),
		.evicted     (evicted)
	);

endmodule
